FILE: rtl/core/gfc_pkg.sv
package gfc_pkg;

    localparam int CANVAS_DIM_DEF = 256;

    // coordinates reach left + x <= 765, canvas dims <= 511
    localparam int COORD_W = 10;
    // linear readout position and row counter
    localparam int POS_W = 2 * COORD_W;
    localparam int DIV_CNT_W = $clog2(POS_W + 1);

    localparam logic [1:0] FUNC_HEADER = 2'd0;
    localparam logic [1:0] FUNC_PIXEL  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_EOF    = 2'd3;

    localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND    = 2'd2;

    localparam logic [2:0] DISP_BACKGROUND = 3'd2;
    localparam logic [2:0] DISP_PREVIOUS   = 3'd3;
    localparam logic [2:0] DISP_DRAW_MAX   = 3'd3;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] top;
        logic [8:0] width;
        logic [8:0] height;
        logic [2:0] disposal;
        logic       ext;
        logic       trans_en;
        logic [7:0] transp_idx;
        logic       first;
    } hdr_t;

    typedef struct packed {
        logic               active;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } walk_stat_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COORD_W-1:0] rem;
        logic [POS_W-1:0]   quo;
    } div_stat_t;

    // zero acts as one, anything above the store size is clamped
    function automatic logic [COORD_W-1:0] eff_dim(input logic [8:0] v, input int dim);
        logic [COORD_W-1:0] r;
        begin
            r = COORD_W'(v);
            if (v == 9'd0) begin
                r = COORD_W'(1);
            end else if (int'(v) > dim) begin
                r = COORD_W'(dim);
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/gif_frame_compositor_top.sv
// Indexed-color frame compositor with GIF disposal. Pixel items write one canvas entry each
// and are taken every cycle while idle with no division running; a readout item is not
// taken while the previous readout is pending, since the canvas memory read is registered.
// A header with the first-frame flag fills the whole canvas store, then, for
// restore-to-previous, walks the clipped rectangle at one pixel per cycle to save it; a
// restore-to-previous header without the flag walks to save at once. End of frame walks the
// clipped rectangle at one pixel per cycle for the clear or restore. Writing canvas_width
// recomputes the readout column and row with a serial divider; no item is taken until the
// divider result has been loaded.
module gif_frame_compositor_top import gfc_pkg::*; #(
    parameter int CANVAS_DIM = CANVAS_DIM_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_frame_left,
    input  logic [7:0] s_frame_top,
    input  logic [8:0] s_frame_width,
    input  logic [8:0] s_frame_height,
    input  logic [2:0] s_disposal,
    input  logic       s_ext_active,
    input  logic       s_trans_enable,
    input  logic [7:0] s_trans_index,
    input  logic       s_first_frame,
    input  logic [7:0] s_pixel_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_canvas_pixel,
    output logic       m_last_of_canvas
);

    localparam int AWC = $clog2(CANVAS_DIM);
    localparam int AW = 2 * AWC;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FILL   = 3'd1;
    localparam logic [2:0] ST_WSTART = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;

    localparam logic [1:0] WK_SAVE    = 2'd0;
    localparam logic [1:0] WK_CLEAR   = 2'd1;
    localparam logic [1:0] WK_RESTORE = 2'd2;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         kind_reg, kind_next;
    hdr_t               hdr_reg, hdr_next;
    logic [8:0]         cw_reg, ch_reg;
    logic [7:0]         bg_reg;
    logic [8:0]         draw_x_reg, draw_x_next;
    logic [8:0]         draw_y_reg, draw_y_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COORD_W-1:0] rx_reg, rx_next;
    logic [POS_W-1:0]   ry_reg, ry_next;
    logic [AW-1:0]      fill_cnt_reg, fill_cnt_next;
    logic [7:0]         fill_val_reg, fill_val_next;
    logic               rd_pend_reg, rd_last_reg, rd_last_next;
    logic               cp_pend_reg, cp_to_canvas_reg;
    logic [AW-1:0]      cp_addr_reg;
    logic               m_valid_reg;
    logic [7:0]         m_pixel_reg;
    logic               m_last_reg;
    logic               div_start_reg;

    logic [COORD_W-1:0] cw_eff, ch_eff;
    logic               s_fire, cfg_fire, rd_ok;
    logic               wrap, rd_last;
    logic [COORD_W-1:0] ex;
    logic [POS_W-1:0]   ey, ep;
    logic [COORD_W-1:0] px, py;
    logic               pix_in_rect, pix_draws, pix_trans;
    logic               walk_start;
    walk_stat_t         walk;
    div_stat_t          div;
    logic [AW-1:0]      walk_addr;

    logic               canvas_we, saved_we;
    logic [AW-1:0]      canvas_waddr, canvas_raddr, saved_waddr, saved_raddr;
    logic [7:0]         canvas_wdata, canvas_rdata, saved_wdata, saved_rdata;

    assign cw_eff = eff_dim(cw_reg, CANVAS_DIM);
    assign ch_eff = eff_dim(ch_reg, CANVAS_DIM);

    assign cfg_ready = 1'b1;
    assign cfg_fire = cfg_valid && cfg_ready;

    // a readout needs the output register free when the memory data lands
    assign rd_ok = !rd_pend_reg && (!m_valid_reg || m_ready);
    // the divider result is loaded in its done cycle, so nothing is taken then either
    assign s_ready = (state_reg == ST_IDLE) && !div.busy && !div_start_reg && !div.done &&
                     ((s_func != FUNC_READ) || rd_ok);
    assign s_fire = s_valid && s_ready;

    // readout position, wrapped if it lies beyond the canvas
    always_comb begin
        wrap = ry_reg >= POS_W'(ch_eff);
        ex = wrap ? '0 : rx_reg;
        ey = wrap ? '0 : ry_reg;
        ep = wrap ? '0 : pos_reg;
        rd_last = (ex == cw_eff - COORD_W'(1)) && (ey == POS_W'(ch_eff) - POS_W'(1));
    end

    always_comb begin
        px = COORD_W'(hdr_reg.left) + COORD_W'(draw_x_reg);
        py = COORD_W'(hdr_reg.top) + COORD_W'(draw_y_reg);
        pix_in_rect = (hdr_reg.width != 9'd0) && (draw_y_reg < hdr_reg.height);
        pix_draws = !hdr_reg.ext || (hdr_reg.disposal <= DISP_DRAW_MAX);
        pix_trans = hdr_reg.ext && hdr_reg.trans_en && (s_pixel_value == hdr_reg.transp_idx);
    end

    assign walk_addr = {walk.y[AWC-1:0], walk.x[AWC-1:0]};
    assign walk_start = (state_reg == ST_WSTART);

    always_comb begin
        state_next = state_reg;
        kind_next = kind_reg;
        hdr_next = hdr_reg;
        draw_x_next = draw_x_reg;
        draw_y_next = draw_y_reg;
        pos_next = pos_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        fill_cnt_next = fill_cnt_reg;
        fill_val_next = fill_val_reg;
        rd_last_next = rd_last_reg;

        canvas_we = 1'b0;
        canvas_waddr = {py[AWC-1:0], px[AWC-1:0]};
        canvas_wdata = s_pixel_value;
        canvas_raddr = {ey[AWC-1:0], ex[AWC-1:0]};
        saved_we = 1'b0;
        saved_waddr = cp_addr_reg;
        saved_wdata = canvas_rdata;
        saved_raddr = walk_addr;

        if (div.done) begin
            rx_next = div.rem;
            ry_next = div.quo;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_func)
                        FUNC_HEADER: begin
                            hdr_next.left = s_frame_left;
                            hdr_next.top = s_frame_top;
                            hdr_next.width = s_frame_width;
                            hdr_next.height = s_frame_height;
                            hdr_next.disposal = s_disposal;
                            hdr_next.ext = s_ext_active;
                            hdr_next.trans_en = s_trans_enable;
                            hdr_next.transp_idx = s_trans_index;
                            hdr_next.first = s_first_frame;
                            draw_x_next = 9'd0;
                            draw_y_next = 9'd0;
                            pos_next = '0;
                            rx_next = '0;
                            ry_next = '0;
                            fill_cnt_next = '0;
                            fill_val_next = (s_ext_active && s_trans_enable) ?
                                            s_trans_index : bg_reg;
                            kind_next = WK_SAVE;
                            if (s_first_frame) begin
                                state_next = ST_FILL;
                            end else if (s_ext_active && s_disposal == DISP_PREVIOUS) begin
                                state_next = ST_WSTART;
                            end
                        end
                        FUNC_PIXEL: begin
                            if (pix_in_rect) begin
                                canvas_we = pix_draws && !pix_trans &&
                                            (px < cw_eff) && (py < ch_eff);
                                if (COORD_W'(draw_x_reg) + COORD_W'(1) >=
                                    COORD_W'(hdr_reg.width)) begin
                                    draw_x_next = 9'd0;
                                    draw_y_next = draw_y_reg + 9'd1;
                                end else begin
                                    draw_x_next = draw_x_reg + 9'd1;
                                end
                            end
                        end
                        FUNC_READ: begin
                            rd_last_next = rd_last;
                            if (rd_last) begin
                                pos_next = '0;
                                rx_next = '0;
                                ry_next = '0;
                            end else begin
                                pos_next = ep + POS_W'(1);
                                if (ex + COORD_W'(1) == cw_eff) begin
                                    rx_next = '0;
                                    ry_next = ey + POS_W'(1);
                                end else begin
                                    rx_next = ex + COORD_W'(1);
                                    ry_next = ey;
                                end
                            end
                        end
                        default: begin
                            draw_x_next = 9'd0;
                            draw_y_next = hdr_reg.height;
                            if (hdr_reg.ext && hdr_reg.disposal == DISP_BACKGROUND) begin
                                kind_next = WK_CLEAR;
                                state_next = ST_WSTART;
                            end else if (hdr_reg.ext && hdr_reg.disposal == DISP_PREVIOUS) begin
                                kind_next = WK_RESTORE;
                                state_next = ST_WSTART;
                            end
                        end
                    endcase
                end
            end
            ST_FILL: begin
                canvas_we = 1'b1;
                canvas_waddr = fill_cnt_reg;
                canvas_wdata = fill_val_reg;
                fill_cnt_next = fill_cnt_reg + AW'(1);
                if (fill_cnt_reg == {AW{1'b1}}) begin
                    if (hdr_reg.ext && hdr_reg.disposal == DISP_PREVIOUS) begin
                        state_next = ST_WSTART;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WSTART: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                canvas_raddr = walk_addr;
                if (walk.active && kind_reg == WK_CLEAR) begin
                    canvas_we = 1'b1;
                    canvas_waddr = walk_addr;
                    canvas_wdata = bg_reg;
                end
                if (!walk.active) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // second half of a save or restore copy, in the cycle after the read
        if (cp_pend_reg) begin
            if (cp_to_canvas_reg) begin
                canvas_we = 1'b1;
                canvas_waddr = cp_addr_reg;
                canvas_wdata = saved_rdata;
            end else begin
                saved_we = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg <= WK_SAVE;
            hdr_reg <= '0;
            draw_x_reg <= 9'd0;
            draw_y_reg <= 9'd0;
            pos_reg <= '0;
            rx_reg <= '0;
            ry_reg <= '0;
            cw_reg <= 9'd256;
            ch_reg <= 9'd256;
            bg_reg <= 8'd0;
            rd_pend_reg <= 1'b0;
            cp_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            kind_reg <= kind_next;
            hdr_reg <= hdr_next;
            draw_x_reg <= draw_x_next;
            draw_y_reg <= draw_y_next;
            pos_reg <= pos_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            div_start_reg <= cfg_fire && (cfg_index == CFG_CANVAS_WIDTH);
            if (cfg_fire) begin
                case (cfg_index)
                    CFG_CANVAS_WIDTH:  cw_reg <= cfg_data;
                    CFG_CANVAS_HEIGHT: ch_reg <= cfg_data;
                    CFG_BACKGROUND:    bg_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            rd_pend_reg <= s_fire && (s_func == FUNC_READ);
            cp_pend_reg <= (state_reg == ST_WALK) && walk.active && (kind_reg != WK_CLEAR);
            if (rd_pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fill_cnt_reg <= fill_cnt_next;
        fill_val_reg <= fill_val_next;
        rd_last_reg <= rd_last_next;
        cp_addr_reg <= walk_addr;
        cp_to_canvas_reg <= (kind_reg == WK_RESTORE);
        if (rd_pend_reg) begin
            m_pixel_reg <= canvas_rdata;
            m_last_reg <= rd_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_canvas_pixel = m_pixel_reg;
    assign m_last_of_canvas = m_last_reg;

    gfc_store #(
        .CANVAS_DIM(CANVAS_DIM)
    ) u_store (
        .aclk        (aclk),
        .canvas_we   (canvas_we),
        .canvas_waddr(canvas_waddr),
        .canvas_wdata(canvas_wdata),
        .canvas_raddr(canvas_raddr),
        .canvas_rdata(canvas_rdata),
        .saved_we    (saved_we),
        .saved_waddr (saved_waddr),
        .saved_wdata (saved_wdata),
        .saved_raddr (saved_raddr),
        .saved_rdata (saved_rdata)
    );

    gfc_walker u_walker (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (walk_start),
        .hdr    (hdr_reg),
        .cw     (cw_eff),
        .ch     (ch_eff),
        .stat   (walk)
    );

    gfc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .dividend(pos_reg),
        .divisor (cw_eff),
        .stat    (div)
    );

    a_rd_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |=> m_valid_reg)
        else $error("readout data did not reach the output register");

    a_rd_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> !(m_valid_reg && !m_ready))
        else $error("readout data would overwrite a result not yet taken");

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE || div.busy) |-> !s_ready)
        else $error("item taken while a walk, fill or division is running");

    a_copy_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        cp_pend_reg |-> $past(state_reg) == ST_WALK)
        else $error("copy write without a walk read");

endmodule

FILE: rtl/core/gfc_store.sv
module gfc_store import gfc_pkg::*; #(
    parameter int CANVAS_DIM = CANVAS_DIM_DEF,
    localparam int AW = 2 * $clog2(CANVAS_DIM)
) (
    input  logic          aclk,
    input  logic          canvas_we,
    input  logic [AW-1:0] canvas_waddr,
    input  logic [7:0]    canvas_wdata,
    input  logic [AW-1:0] canvas_raddr,
    output logic [7:0]    canvas_rdata,
    input  logic          saved_we,
    input  logic [AW-1:0] saved_waddr,
    input  logic [7:0]    saved_wdata,
    input  logic [AW-1:0] saved_raddr,
    output logic [7:0]    saved_rdata
);

    logic [7:0] canvas_mem [2**AW];
    logic [7:0] saved_mem  [2**AW];

    always_ff @(posedge aclk) begin
        if (canvas_we) begin
            canvas_mem[canvas_waddr] <= canvas_wdata;
        end
        canvas_rdata <= canvas_mem[canvas_raddr];
    end

    always_ff @(posedge aclk) begin
        if (saved_we) begin
            saved_mem[saved_waddr] <= saved_wdata;
        end
        saved_rdata <= saved_mem[saved_raddr];
    end

endmodule

FILE: rtl/core/gfc_walker.sv
module gfc_walker import gfc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  hdr_t               hdr,
    input  logic [COORD_W-1:0] cw,
    input  logic [COORD_W-1:0] ch,
    output walk_stat_t         stat
);

    logic [8:0]         wx_reg, wx_next;
    logic [8:0]         wy_reg, wy_next;
    logic               active_reg, active_next;
    logic [COORD_W-1:0] cx, cy;
    logic               x_more, y_more;

    always_comb begin
        cx = COORD_W'(hdr.left) + COORD_W'(wx_reg);
        cy = COORD_W'(hdr.top) + COORD_W'(wy_reg);
        x_more = (COORD_W'(wx_reg) + COORD_W'(1) < COORD_W'(hdr.width)) &&
                 (cx + COORD_W'(1) < cw);
        y_more = (COORD_W'(wy_reg) + COORD_W'(1) < COORD_W'(hdr.height)) &&
                 (cy + COORD_W'(1) < ch);
        wx_next = wx_reg;
        wy_next = wy_reg;
        active_next = active_reg;
        if (start) begin
            wx_next = 9'd0;
            wy_next = 9'd0;
            active_next = (hdr.width != 9'd0) && (hdr.height != 9'd0) &&
                          (COORD_W'(hdr.left) < cw) && (COORD_W'(hdr.top) < ch);
        end else if (active_reg) begin
            if (x_more) begin
                wx_next = wx_reg + 9'd1;
            end else begin
                wx_next = 9'd0;
                if (y_more) begin
                    wy_next = wy_reg + 9'd1;
                end else begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            wx_reg <= 9'd0;
            wy_reg <= 9'd0;
        end else begin
            active_reg <= active_next;
            wx_reg <= wx_next;
            wy_reg <= wy_next;
        end
    end

    assign stat.active = active_reg;
    assign stat.x = cx;
    assign stat.y = cy;

endmodule

FILE: rtl/core/gfc_div.sv
module gfc_div import gfc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [POS_W-1:0]   dividend,
    input  logic [COORD_W-1:0] divisor,
    output div_stat_t          stat
);

    logic                 busy_reg, done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [COORD_W-1:0]   rem_reg;
    logic [POS_W-1:0]     quo_reg;
    logic [COORD_W:0]     shifted;
    logic [COORD_W:0]     diff;
    logic                 fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[POS_W-1]};
        fits = shifted >= {1'b0, divisor};
        diff = shifted - {1'b0, divisor};
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(POS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
            quo_reg <= {quo_reg[POS_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem = rem_reg;
    assign stat.quo = quo_reg;

endmodule
